>>> hw/rtl/lzpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzpd_pkg
// Shared types and constants of the packet LZ decompressor.
// ----------------------------------------------------------------------------
package lzpd_pkg;

    localparam int unsigned LANES      = 8;
    localparam int unsigned TOTAL_W    = 22;
    localparam int unsigned LEN_W      = 9;
    localparam int unsigned DIST_W     = 11;
    localparam logic [TOTAL_W-1:0] MAX_PIXELS = 22'd4000000;

    localparam logic [2:0] PH_CTRL       = 3'd0;
    localparam logic [2:0] PH_LEAD       = 3'd1;
    localparam logic [2:0] PH_LONG_DIST  = 3'd2;
    localparam logic [2:0] PH_LONG_LEN   = 3'd3;
    localparam logic [2:0] PH_SHORT_DIST = 3'd4;
    localparam logic [2:0] PH_RUN_LEN    = 3'd5;

    typedef struct packed {
        logic clr_step;
        logic take_byte;
        logic pix_read;
        logic pix_write;
        logic emit_mid;
        logic emit_last;
        logic image_reset;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic burst_left;
        logic buf_full;
        logic buf_nonempty;
        logic end_flag;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/lzpd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzpd_ctrl
// Sequencer: history clear, byte intake, per-pixel read/write, result emit.
// ----------------------------------------------------------------------------
module lzpd_ctrl
    import lzpd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  sts_t      sts,
    output cmd_t      cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take_byte = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (sts.burst_left) begin
                    if (!sts.buf_full) begin
                        cmd.pix_read = 1'b1;
                        state_next   = S_WRITE;
                    end else if (sts.out_free) begin
                        cmd.emit_mid = 1'b1;
                    end
                end else if (sts.buf_nonempty || sts.end_flag) begin
                    if (sts.out_free) begin
                        cmd.emit_last   = 1'b1;
                        cmd.image_reset = sts.end_flag;
                        state_next      = sts.end_flag ? S_CLEAR : S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_WRITE: begin
                cmd.pix_write = 1'b1;
                state_next    = S_CHECK;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/lzpd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzpd_datapath
// Packet parser, history memory, lane packer and result register.
// ----------------------------------------------------------------------------
module lzpd_datapath
    import lzpd_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  wire logic              cfg_valid,
    input  wire logic [TOTAL_W-1:0] cfg_data,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_stream_end,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output logic [7:0]             m_pixel [LANES],
    output logic [3:0]             m_lane_count,
    output logic                   m_run_last,
    output logic                   m_image_complete,
    output logic                   m_stream_short
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W   = (AW+1)'(HISTORY_DEPTH);

    logic [7:0] hist_mem [HISTORY_DEPTH];

    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] emitted_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      wp_reg;
    logic [AW-1:0]      src_reg, src_next;
    logic [2:0]         phase_reg, phase_next;
    logic [7:0]         flags_reg, flags_next;
    logic [2:0]         slot_reg, slot_next;
    logic [7:0]         acc_reg, acc_next;
    logic [1:0]         used_reg, used_next;
    logic [7:0]         lead_reg, lead_next;
    logic [DIST_W-1:0]  pdist_reg, pdist_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               copy_reg, copy_next;
    logic [4:0]         runv_reg, runv_next;
    logic               end_reg;
    logic [7:0]         rd_reg;
    logic [7:0]         lane_reg [LANES];
    logic [3:0]         cnt_reg;

    logic [7:0]         acc_new;
    logic [DIST_W-1:0]  copy_dist;
    logic [AW:0]        src_tmp;
    logic [7:0]         pixel;
    logic [7:0]         out_pix_reg [LANES];
    logic [3:0]         out_cnt_reg;
    logic               out_valid_reg, out_last_reg, out_cplt_reg, out_short_reg;
    logic               out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign pixel    = copy_reg ? rd_reg : {3'b000, runv_reg};

    assign sts.clr_done     = (clr_addr_reg == LAST_ADDR);
    assign sts.burst_left   = (len_reg != '0) && (emitted_reg < total_reg);
    assign sts.buf_full     = (cnt_reg == 4'(LANES));
    assign sts.buf_nonempty = (cnt_reg != '0);
    assign sts.end_flag     = end_reg;
    assign sts.out_free     = out_free;

    // packet parser
    always_comb begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        slot_next  = slot_reg;
        acc_next   = acc_reg;
        used_next  = used_reg;
        lead_next  = lead_reg;
        pdist_next = pdist_reg;
        len_next   = '0;
        copy_next  = copy_reg;
        runv_next  = runv_reg;
        copy_dist  = '0;
        acc_new    = acc_reg | ({s_data_byte[7:6], 6'b0} >> {used_reg, 1'b0});
        unique case (phase_reg)
            PH_CTRL: begin
                flags_next = s_data_byte;
                slot_next  = '0;
                phase_next = PH_LEAD;
            end
            PH_LEAD: begin
                if (flags_reg[slot_reg]) begin
                    if (s_data_byte[5:0] == '0) begin
                        lead_next  = s_data_byte;
                        phase_next = PH_LONG_DIST;
                    end else if (used_reg != 2'd3) begin
                        acc_next   = acc_new;
                        used_next  = used_reg + 2'd1;
                        lead_next  = s_data_byte;
                        phase_next = PH_SHORT_DIST;
                    end else begin
                        acc_next  = '0;
                        used_next = '0;
                        copy_dist = DIST_W'(acc_new) + DIST_W'(1);
                        len_next  = LEN_W'(s_data_byte[5:0]) + LEN_W'(1);
                        copy_next = 1'b1;
                    end
                end else begin
                    if (s_data_byte[7:5] == '0) begin
                        lead_next  = s_data_byte;
                        phase_next = PH_RUN_LEN;
                    end else begin
                        runv_next = s_data_byte[4:0];
                        len_next  = LEN_W'(s_data_byte[7:5]);
                        copy_next = 1'b0;
                    end
                end
            end
            PH_LONG_DIST: begin
                pdist_next = {1'b0, lead_reg[7:6], s_data_byte} + DIST_W'(1);
                phase_next = PH_LONG_LEN;
            end
            PH_LONG_LEN: begin
                copy_dist = pdist_reg;
                len_next  = LEN_W'(s_data_byte) + LEN_W'(3);
                copy_next = 1'b1;
            end
            PH_SHORT_DIST: begin
                copy_dist = DIST_W'(s_data_byte) + DIST_W'(1);
                len_next  = LEN_W'(lead_reg[5:0]) + LEN_W'(1);
                copy_next = 1'b1;
            end
            PH_RUN_LEN: begin
                runv_next = lead_reg[4:0];
                len_next  = LEN_W'(s_data_byte) + LEN_W'(8);
                copy_next = 1'b0;
            end
            default: phase_next = PH_CTRL;
        endcase
        // packet finished in this byte
        if (phase_reg != PH_CTRL && phase_next == phase_reg && phase_reg != PH_LONG_DIST
            || phase_reg == PH_LEAD && phase_next == PH_LEAD
            || phase_reg == PH_LONG_LEN || phase_reg == PH_SHORT_DIST
            || phase_reg == PH_RUN_LEN) begin
            slot_next  = slot_reg + 3'd1;
            phase_next = (slot_reg == 3'd7) ? PH_CTRL : PH_LEAD;
        end
        src_tmp  = {1'b0, wp_reg} + DEPTH_W - (AW+1)'(copy_dist);
        src_next = (src_tmp >= DEPTH_W) ? AW'(src_tmp - DEPTH_W) : AW'(src_tmp);
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            hist_mem[clr_addr_reg] <= '0;
        end else if (cmd.pix_write) begin
            hist_mem[wp_reg] <= pixel;
        end
        if (cmd.pix_read) begin
            rd_reg <= hist_mem[src_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.image_reset) begin
            clr_addr_reg <= '0;
            wp_reg       <= '0;
            emitted_reg  <= '0;
            phase_reg    <= PH_CTRL;
            flags_reg    <= '0;
            slot_reg     <= '0;
            acc_reg      <= '0;
            used_reg     <= '0;
            lead_reg     <= '0;
            pdist_reg    <= '0;
            len_reg      <= '0;
            cnt_reg      <= '0;
            end_reg      <= 1'b0;
        end else begin
            if (cmd.clr_step && clr_addr_reg != LAST_ADDR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.take_byte) begin
                phase_reg <= phase_next;
                flags_reg <= flags_next;
                slot_reg  <= slot_next;
                acc_reg   <= acc_next;
                used_reg  <= used_next;
                lead_reg  <= lead_next;
                pdist_reg <= pdist_next;
                len_reg   <= len_next;
                copy_reg  <= copy_next;
                runv_reg  <= runv_next;
                src_reg   <= src_next;
                end_reg   <= s_stream_end;
            end
            if (cmd.pix_write) begin
                lane_reg[cnt_reg[2:0]] <= pixel;
                cnt_reg     <= cnt_reg + 4'd1;
                len_reg     <= len_reg - LEN_W'(1);
                emitted_reg <= emitted_reg + TOTAL_W'(1);
                wp_reg      <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
                src_reg     <= (src_reg == LAST_ADDR) ? '0 : src_reg + AW'(1);
            end
            if (cmd.emit_mid || cmd.emit_last) begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (cfg_valid) begin
            total_reg <= (cfg_data > MAX_PIXELS) ? '0 : cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_mid || cmd.emit_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_mid || cmd.emit_last) begin
            for (int k = 0; k < LANES; k++) begin
                out_pix_reg[k] <= (4'(k) < cnt_reg) ? lane_reg[k] : 8'd0;
            end
            out_cnt_reg   <= cnt_reg;
            out_last_reg  <= cmd.emit_last;
            out_cplt_reg  <= (emitted_reg >= total_reg);
            out_short_reg <= cmd.emit_last && end_reg && (emitted_reg < total_reg);
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_pixel          = out_pix_reg;
    assign m_lane_count     = out_cnt_reg;
    assign m_run_last       = out_last_reg;
    assign m_image_complete = out_cplt_reg;
    assign m_stream_short   = out_short_reg;

endmodule
`default_nettype wire

>>> hw/rtl/lz_packet_decompressor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lz_packet_decompressor_unit
// Packet LZ decoder: compressed bytes in, eight-lane pixel results out.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// s_       in         s_valid / s_ready      data_byte, stream_end
// m_       out        m_valid / m_ready      pixel_0..7, lane_count, flags
// cfg_     in         cfg_valid / cfg_ready  pixel_total (22 bits)
//
// A byte is taken while idle, then each decoded pixel is read and written and
// each result emitted before s_ready rises for the next byte; the single-port
// history memory (read, then write) sets the pixel rate. After reset and after
// each stream_end transaction the history is cleared with s_ready low.
// A stalled m_ready holds the sequencer at a full lane buffer or at the last
// result of a byte.
// ----------------------------------------------------------------------------
module lz_packet_decompressor_unit
    import lzpd_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [TOTAL_W-1:0] cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_data_byte,
    input  wire logic               s_stream_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_pixel_0,
    output logic [7:0]              m_pixel_1,
    output logic [7:0]              m_pixel_2,
    output logic [7:0]              m_pixel_3,
    output logic [7:0]              m_pixel_4,
    output logic [7:0]              m_pixel_5,
    output logic [7:0]              m_pixel_6,
    output logic [7:0]              m_pixel_7,
    output logic [3:0]              m_lane_count,
    output logic                    m_run_last,
    output logic                    m_image_complete,
    output logic                    m_stream_short
);

    cmd_t       cmd;
    sts_t       sts;
    logic [7:0] pix [LANES];

    assign cfg_ready = 1'b1;

    lzpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lzpd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .s_data_byte      (s_data_byte),
        .s_stream_end     (s_stream_end),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_pixel          (pix),
        .m_lane_count     (m_lane_count),
        .m_run_last       (m_run_last),
        .m_image_complete (m_image_complete),
        .m_stream_short   (m_stream_short)
    );

    assign m_pixel_0 = pix[0];
    assign m_pixel_1 = pix[1];
    assign m_pixel_2 = pix[2];
    assign m_pixel_3 = pix[3];
    assign m_pixel_4 = pix[4];
    assign m_pixel_5 = pix[5];
    assign m_pixel_6 = pix[6];
    assign m_pixel_7 = pix[7];

endmodule
`default_nettype wire

>>> hw/rtl/lzpd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzpd_checker
// Port-level checks of the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzpd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [3:0] m_lane_count,
    input wire logic       m_run_last,
    input wire logic       m_image_complete,
    input wire logic       m_stream_short
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lane_count))
        else $error("result dropped or changed while stalled");

    a_lane_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_lane_count <= 4'd8)
        else $error("lane count out of range");

    a_short_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_short |-> m_run_last && !m_image_complete)
        else $error("short stream flag on wrong result");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lane_count == 4'd0 |-> m_run_last)
        else $error("empty result not last");

    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("transaction accepted while busy");

endmodule

bind lz_packet_decompressor_unit lzpd_checker u_lzpd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_lane_count     (m_lane_count),
    .m_run_last       (m_run_last),
    .m_image_complete (m_image_complete),
    .m_stream_short   (m_stream_short)
);
`default_nettype wire

>>> dv/lz_packet_decompressor_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_packet_decompressor_unit_test
// Drives compressed packet streams into the decoder under random handshake
// gaps, predicts every eight-lane pixel transaction and compares field by field.
// ----------------------------------------------------------------------------
module lz_packet_decompressor_unit_test;
    import lzpd_pkg::*;

    localparam int HIST      = 1024;
    localparam int BURST_CAP = 264;
    localparam int IDLE_MAX  = 6000;
    localparam int SETTLE    = 1200;

    typedef struct packed {
        logic [7:0][7:0] pix;
        logic [3:0]      lanes;
        logic            last;
        logic            done;
        logic            short_f;
    } pixel_beat_t;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
    } comp_byte_t;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
        logic       typed;
        logic [7:0] val;
        logic [3:0] lanes;
        logic       done;
        logic       short_f;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [TOTAL_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_data_byte = '0;
    logic s_stream_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_pixel_0, m_pixel_1, m_pixel_2, m_pixel_3;
    logic [7:0] m_pixel_4, m_pixel_5, m_pixel_6, m_pixel_7;
    logic [3:0] m_lane_count;
    logic m_run_last, m_image_complete, m_stream_short;

    always #10 aclk = ~aclk;

    lz_packet_decompressor_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_stream_end(s_stream_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pixel_0(m_pixel_0), .m_pixel_1(m_pixel_1), .m_pixel_2(m_pixel_2),
        .m_pixel_3(m_pixel_3), .m_pixel_4(m_pixel_4), .m_pixel_5(m_pixel_5),
        .m_pixel_6(m_pixel_6), .m_pixel_7(m_pixel_7),
        .m_lane_count(m_lane_count), .m_run_last(m_run_last),
        .m_image_complete(m_image_complete), .m_stream_short(m_stream_short)
    );

    // decoder shadow state
    logic [7:0]   hist [HIST];
    int unsigned  wpos, emitted, flags, slot, hacc, hused, plead, pdist;
    logic [2:0]   phase;
    logic [TOTAL_W-1:0] pixel_total;
    logic [7:0]   burst [BURST_CAP];
    int unsigned  burst_n;

    pixel_beat_t  pixel_q[$];
    comp_byte_t   stim_q[$];
    int           errors = 0;
    int           idle_cycles = 0;
    bit           rx_hold = 1'b0;
    bit           no_gaps = 1'b0;

    function automatic int unsigned pixel_limit();
        return (pixel_total > MAX_PIXELS) ? 0 : 32'(pixel_total);
    endfunction

    task automatic clear_image();
        for (int i = 0; i < HIST; i++) hist[i] = 8'h00;
        wpos = 0; emitted = 0; phase = PH_CTRL; flags = 0; slot = 0;
        hacc = 0; hused = 0; plead = 0; pdist = 0;
    endtask

    task automatic put_pixel(input logic [7:0] v);
        if (emitted >= pixel_limit() || burst_n >= BURST_CAP) return;
        hist[wpos] = v;
        wpos = (wpos + 1) % HIST;
        burst[burst_n] = v;
        burst_n++;
        emitted++;
    endtask

    task automatic copy_back(input int unsigned cdist, input int unsigned len);
        int unsigned src;
        for (int unsigned k = 0; k < len; k++) begin
            src = (wpos + HIST - (cdist % (HIST + 1))) % HIST;
            put_pixel(hist[src]);
        end
    endtask

    task automatic run_fill(input logic [4:0] v, input int unsigned len);
        for (int unsigned k = 0; k < len; k++) put_pixel({3'b000, v});
    endtask

    task automatic next_packet();
        slot++;
        if (slot >= 8) begin
            slot = 0;
            phase = PH_CTRL;
        end else begin
            phase = PH_LEAD;
        end
    endtask

    task automatic stim_add(input logic [7:0] b);
        comp_byte_t cb;
        cb.b = b;
        cb.e = 1'b0;
        stim_q.insert(stim_q.size(), cb);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic e);
        int unsigned base, lim, nres, first, lanes, cdist;
        pixel_beat_t r;
        base = emitted;
        lim = pixel_limit();
        burst_n = 0;
        case (phase)
            PH_CTRL: begin
                flags = {24'd0, b}; slot = 0; phase = PH_LEAD;
            end
            PH_LEAD: begin
                if (flags[slot]) begin
                    if (b[5:0] == 6'd0) begin
                        plead = {24'd0, b}; phase = PH_LONG_DIST;
                    end else begin
                        hacc = (hacc | ({24'd0, b[7:6], 6'd0} >> ((hused % 4) * 2))) & 32'hff;
                        hused++;
                        if (hused < 4) begin
                            plead = {24'd0, b}; phase = PH_SHORT_DIST;
                        end else begin
                            cdist = hacc + 1;
                            hacc = 0; hused = 0;
                            copy_back(cdist, {26'd0, b[5:0]} + 1);
                            next_packet();
                        end
                    end
                end else begin
                    if (b[7:5] == 3'd0) begin
                        plead = {24'd0, b}; phase = PH_RUN_LEN;
                    end else begin
                        run_fill(b[4:0], {29'd0, b[7:5]});
                        next_packet();
                    end
                end
            end
            PH_LONG_DIST: begin
                pdist = (((plead & 32'hc0) << 2) | {24'd0, b}) + 1;
                phase = PH_LONG_LEN;
            end
            PH_LONG_LEN: begin
                copy_back(pdist, {24'd0, b} + 3);
                next_packet();
            end
            PH_SHORT_DIST: begin
                copy_back({24'd0, b} + 1, (plead & 32'h3f) + 1);
                next_packet();
            end
            PH_RUN_LEN: begin
                run_fill(plead[4:0], {24'd0, b} + 8);
                next_packet();
            end
            default: phase = PH_CTRL;
        endcase
        nres = (burst_n + LANES - 1) / LANES;
        if (nres == 0 && e) nres = 1;
        for (int unsigned k = 0; k < nres; k++) begin
            first = k * LANES;
            lanes = (burst_n > first) ? burst_n - first : 0;
            if (lanes > LANES) lanes = LANES;
            for (int j = 0; j < 8; j++) r.pix[j] = (j < lanes) ? burst[first + j] : 8'h00;
            r.lanes = 4'(lanes);
            r.last = (k + 1 == nres);
            r.done = (base + first + lanes >= lim);
            r.short_f = r.last && e && (emitted < lim);
            pixel_q.insert(pixel_q.size(), r);
        end
        if (e) clear_image();
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_stream_end <= e;
        do @(posedge aclk); while (!s_ready);
        decode_byte(b, e);
    endtask

    task automatic drain_pixels();
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_total(input logic [TOTAL_W-1:0] v);
        s_valid <= 1'b0;
        drain_pixels();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        pixel_total = v;
        cfg_valid <= 1'b0;
    endtask

    // one well-formed or damaged image into stim_q
    task automatic build_image();
        int mode, groups, scount, start;
        logic [7:0] c, lead;
        mode = $urandom_range(0, 9);
        start = stim_q.size();
        scount = 0;
        if (mode == 0) begin
            repeat ($urandom_range(1, 20)) stim_add(8'($urandom_range(0, 255)));
        end else begin
            groups = $urandom_range(1, 3);
            repeat (groups) begin
                c = 8'($urandom_range(0, 255));
                stim_add(c);
                for (int i = 0; i < 8; i++) begin
                    if (c[i]) begin
                        if ($urandom_range(0, 3) == 0) begin
                            stim_add({2'($urandom_range(0, 3)), 6'd0});
                            stim_add(8'($urandom_range(0, 255)));
                            stim_add(($urandom_range(0, 7) == 0) ?
                                8'($urandom_range(0, 255)) : 8'($urandom_range(0, 30)));
                        end else begin
                            lead = {2'($urandom_range(0, 3)), 6'($urandom_range(1, 63))};
                            if ($urandom_range(0, 3) != 0) lead[5:0] = 6'($urandom_range(1, 12));
                            stim_add(lead);
                            if (scount < 3) stim_add(8'($urandom_range(0, 255)));
                            scount = (scount + 1) % 4;
                        end
                    end else begin
                        if ($urandom_range(0, 3) == 0) begin
                            stim_add({3'd0, 5'($urandom_range(0, 31))});
                            stim_add(($urandom_range(0, 7) == 0) ?
                                8'($urandom_range(0, 255)) : 8'($urandom_range(0, 20)));
                        end else begin
                            stim_add({3'($urandom_range(1, 7)), 5'($urandom_range(0, 31))});
                        end
                    end
                end
            end
            if (mode == 1) begin
                while (stim_q.size() > start + 1 && $urandom_range(0, 3) != 0)
                    void'(stim_q.pop_back());
            end
        end
        stim_q[stim_q.size() - 1].e = 1'b1;
    endtask

    dir_row_t dir_tab[] = '{
        // image A: copies, long/short forms, high-bit collection, total cut
        '{8'hFF, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h41, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h10, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'hC1, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'hC0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h3F, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h05, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h02, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h01, 1'b1, 1'b1, 8'h00, 4'd0, 1'b1, 1'b0},
        // image B: runs
        '{8'h00, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 8'h1F, 4'd7, 1'b0, 1'b0},
        '{8'h05, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 8'h05, 4'd8, 1'b0, 1'b0},
        '{8'h1F, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        '{8'hE0, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0},
        // image C: ends on its control byte
        '{8'h55, 1'b1, 1'b1, 8'h00, 4'd0, 1'b0, 1'b1}
    };

    // result checker and watchdog
    always @(posedge aclk) begin
        pixel_beat_t x;
        pixel_beat_t got;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX) begin
                $display("%0t timeout, %0d results outstanding", $realtime, pixel_q.size());
                $display("Mismatches found");
                $finish;
            end
            if (m_valid && m_ready) begin
                got.pix = {m_pixel_7, m_pixel_6, m_pixel_5, m_pixel_4,
                           m_pixel_3, m_pixel_2, m_pixel_1, m_pixel_0};
                got.lanes = m_lane_count;
                got.last = m_run_last;
                got.done = m_image_complete;
                got.short_f = m_stream_short;
                if (pixel_q.size() == 0) begin
                    $display("%0t unexpected transaction: %h", $realtime, got);
                    errors++;
                end else begin
                    x = pixel_q.pop_front();
                    for (int j = 0; j < 8; j++)
                        if (got.pix[j] !== x.pix[j]) begin
                            $display("%0t pixel_%0d exp %h got %h", $realtime, j,
                                     x.pix[j], got.pix[j]);
                            errors++;
                        end
                    if (got.lanes !== x.lanes) begin
                        $display("%0t lane_count exp %0d got %0d", $realtime, x.lanes, got.lanes);
                        errors++;
                    end
                    if (got.last !== x.last) begin
                        $display("%0t run_last exp %b got %b", $realtime, x.last, got.last);
                        errors++;
                    end
                    if (got.done !== x.done) begin
                        $display("%0t image_complete exp %b got %b", $realtime, x.done, got.done);
                        errors++;
                    end
                    if (got.short_f !== x.short_f) begin
                        $display("%0t stream_short exp %b got %b", $realtime,
                                 x.short_f, got.short_f);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                rx_hold = 1'b0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        logic [TOTAL_W-1:0] totals [8];
        pixel_beat_t t;
        int sent;
        totals = '{22'd4000000, 22'h3FFFFF, 22'd0, 22'd1, 22'd600, 22'd50, 22'd2000, 22'd0};
        totals[7] = 22'($urandom_range(1, 3000));
        pixel_total = '0;
        clear_image();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        set_total(22'd400);
        foreach (dir_tab[i]) begin
            send_byte(dir_tab[i].b, dir_tab[i].e);
            if (dir_tab[i].typed) begin
                void'(pixel_q.pop_back());
                for (int j = 0; j < 8; j++)
                    t.pix[j] = (j < dir_tab[i].lanes) ? dir_tab[i].val : 8'h00;
                t.lanes = dir_tab[i].lanes;
                t.last = 1'b1;
                t.done = dir_tab[i].done;
                t.short_f = dir_tab[i].short_f;
                pixel_q.insert(pixel_q.size(), t);
            end
        end

        for (int p = 0; p < 8; p++) begin
            set_total(totals[p]);
            no_gaps = (p == 4);
            if (p == 2 || p == 5) rx_hold = 1'b1;
            sent = 0;
            while (sent < 32) begin
                build_image();
                while (stim_q.size() != 0) begin
                    comp_byte_t cb;
                    cb = stim_q.pop_front();
                    send_byte(cb.b, cb.e);
                    sent++;
                end
            end
        end
        no_gaps = 1'b0;
        s_valid <= 1'b0;
        drain_pixels();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lzpd_pkg.sv
hw/rtl/lzpd_ctrl.sv
hw/rtl/lzpd_datapath.sv
hw/rtl/lz_packet_decompressor_unit.sv
hw/rtl/lzpd_checker.sv
dv/lz_packet_decompressor_unit_test.sv
